@@ design/idhex_pkg.sv @@
// Package for the identifier text parser: form lengths, ASCII codes and
// the hex digit decoder. No dependencies.

package idhex_pkg;

	// Meaningful character counts of the two forms
	localparam logic [4:0] TraceLen = 5'd19;
	localparam logic [4:0] MsgLen   = 5'd21;
	localparam logic [4:0] PosMax   = 5'd31;

	// Positions inside the message and trace forms
	localparam logic [4:0] MsgPrefixLen = 5'd4;
	localparam logic [4:0] MsgDashPos   = 5'd12;
	localparam logic [4:0] TracePrefixLen = 5'd3;

	// ASCII codes
	localparam logic [7:0] ChNul  = 8'h00;
	localparam logic [7:0] ChDash = 8'h2d;
	localparam logic [7:0] ChT    = 8'h74;
	localparam logic [7:0] ChR    = 8'h72;
	localparam logic [7:0] ChM    = 8'h6d;
	localparam logic [7:0] ChS    = 8'h73;
	localparam logic [7:0] ChG    = 8'h67;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	// Decode one ASCII character as a hex digit, either case
	function automatic hex_digit_t hex_decode(input logic [7:0] c);
		hex_digit_t d;
		d.ok    = 1'b1;
		d.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			d.value = c[3:0];
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			d.value = c[3:0] + 4'd9;
		end else begin
			d.ok = 1'b0;
		end
		return d;
	endfunction

	// Expected prefix character of the message form at a position below four
	function automatic logic [7:0] msg_prefix_char(input logic [1:0] p);
		logic [7:0] c;
		case (p)
			2'd0:    c = ChM;
			2'd1:    c = ChS;
			2'd2:    c = ChG;
			default: c = ChDash;
		endcase
		return c;
	endfunction

	// Expected prefix character of the trace form at a position below three
	function automatic logic [7:0] trace_prefix_char(input logic [1:0] p);
		logic [7:0] c;
		case (p)
			2'd0:    c = ChT;
			2'd1:    c = ChR;
			default: c = ChDash;
		endcase
		return c;
	endfunction

endpackage

@@ design/id_hex_text_parser.sv @@
// Identifier text parser, top level: input register, per-character check
// and accumulate, result register. Depends on idhex_pkg.

// The block takes one character request per cycle on text_valid/text_ready
// and checks the string against "tr-" plus 16 hex digits (want_msg 0 on the
// first byte) or "msg-", 8 hex digits, '-', 8 hex digits (want_msg 1). Each
// request passes the input register and then the check and 4-bit shift into
// the 64-bit accumulator in the parser state; the block sustains one
// character per cycle but for the stall below. Only the request
// marked final_byte produces a result on id_valid/id_ready: id_ok and
// id_value (zero when id_ok is 0); the parser then starts a new string. A
// zero byte ends the text and later bytes up to the final one are ignored.
// Input is stalled only while a final character waits on a full result
// register.

module id_hex_text_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_ready,
	input  logic [7:0]  text_byte,
	input  logic        want_msg,
	input  logic        final_byte,
	output logic        id_valid,
	input  logic        id_ready,
	output logic        id_ok,
	output logic [63:0] id_value
);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       want_s1;
	logic       final_s1;

	// Parser state
	logic [4:0]  pos_q;
	logic        msg_q;
	logic        err_q;
	logic        ended_q;
	logic [63:0] acc_q;

	// Result register
	logic        out_valid_q;
	logic        ok_q;
	logic [63:0] value_q;

	logic advance;
	logic out_free;

	// Next-state values for the character in stage 1
	logic        first_char;
	logic        form_msg;
	logic [4:0]  pos_d;
	logic        err_d;
	logic        ended_d;
	logic [63:0] acc_d;
	logic        bad_char;
	logic        take_digit;
	idhex_pkg::hex_digit_t digit;
	logic        result_ok;

	assign out_free   = !out_valid_q || id_ready;
	assign advance    = valid_s1 && (!final_s1 || out_free);
	assign text_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_ready && text_valid) begin
			byte_s1  <= text_byte;
			want_s1  <= want_msg;
			final_s1 <= final_byte;
		end
	end

	// Character check against its position in the form
	always_comb begin
		first_char = (pos_q == 5'd0) && !ended_q;
		form_msg   = first_char ? want_s1 : msg_q;
		digit      = idhex_pkg::hex_decode(byte_s1);
		bad_char   = 1'b0;
		take_digit = 1'b0;
		if (form_msg) begin
			if (pos_q < idhex_pkg::MsgPrefixLen) begin
				bad_char = byte_s1 != idhex_pkg::msg_prefix_char(pos_q[1:0]);
			end else if (pos_q == idhex_pkg::MsgDashPos) begin
				bad_char = byte_s1 != idhex_pkg::ChDash;
			end else if (pos_q < idhex_pkg::MsgLen) begin
				take_digit = 1'b1;
			end else begin
				bad_char = 1'b1;
			end
		end else begin
			if (pos_q < idhex_pkg::TracePrefixLen) begin
				bad_char = byte_s1 != idhex_pkg::trace_prefix_char(pos_q[1:0]);
			end else if (pos_q < idhex_pkg::TraceLen) begin
				take_digit = 1'b1;
			end else begin
				bad_char = 1'b1;
			end
		end
		if (take_digit && !digit.ok) begin
			bad_char = 1'b1;
		end

		pos_d   = pos_q;
		err_d   = err_q;
		ended_d = ended_q;
		acc_d   = acc_q;
		if (!ended_q) begin
			if (byte_s1 == idhex_pkg::ChNul) begin
				ended_d = 1'b1;
			end else begin
				if (bad_char) begin
					err_d = 1'b1;
				end
				if (take_digit && digit.ok) begin
					acc_d = {acc_q[59:0], digit.value};
				end
				if (pos_q != idhex_pkg::PosMax) begin
					pos_d = pos_q + 5'd1;
				end
			end
		end

		result_ok = !err_d &&
			(pos_d == (form_msg ? idhex_pkg::MsgLen : idhex_pkg::TraceLen));
	end

	// Parser state: cleared after the final character of a string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 5'd0;
			msg_q   <= 1'b0;
			err_q   <= 1'b0;
			ended_q <= 1'b0;
			acc_q   <= 64'd0;
		end else if (advance) begin
			if (final_s1) begin
				pos_q   <= 5'd0;
				msg_q   <= 1'b0;
				err_q   <= 1'b0;
				ended_q <= 1'b0;
				acc_q   <= 64'd0;
			end else begin
				pos_q   <= pos_d;
				msg_q   <= form_msg;
				err_q   <= err_d;
				ended_q <= ended_d;
				acc_q   <= acc_d;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && final_s1) begin
			out_valid_q <= 1'b1;
		end else if (id_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && final_s1) begin
			ok_q    <= result_ok;
			value_q <= result_ok ? acc_d : 64'd0;
		end
	end

	assign id_valid = out_valid_q;
	assign id_ok    = ok_q;
	assign id_value = value_q;

	// A failed result never carries a value
	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		id_valid && !id_ok |-> id_value == 64'd0)
		else $error("id_value not zero on a failed result");

	// An empty input register never stalls the sender
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> text_ready)
		else $error("input stalled with an empty input register");

	// After a final character the parser starts clean
	a_clear_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		advance && final_s1 |=> pos_q == 5'd0 && !err_q && !ended_q)
		else $error("parser state not cleared after final character");

	// Counting past the message length always flags a form error
	a_long_is_error: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q > idhex_pkg::MsgLen |-> err_q)
		else $error("overlong text without form error");

endmodule

@@ tb/tb.sv @@
// Testbench for id_hex_text_parser: drives identifier text one character per
// request, predicts each parse result and checks it. Depends on idhex_pkg.
`timescale 1ns / 1ps

module tb;

	localparam int CycleLimit = 400000;

	typedef struct packed {
		logic        ok;
		logic [63:0] value;
	} id_result_t;

	typedef enum int {DigitsRandom, DigitsZero, DigitsMax} digit_mode_t;
	typedef enum int {CutShort, AddTail, Corrupt, ZeroCut, SwapForm, PrefixCase, ZeroEnd}
		break_kind_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        text_valid = 1'b0;
	logic        text_ready;
	logic [7:0]  text_byte = 8'h00;
	logic        want_msg = 1'b0;
	logic        final_byte = 1'b0;
	logic        id_valid;
	logic        id_ready = 1'b0;
	logic        id_ok;
	logic [63:0] id_value;

	// Parser state as the testbench sees it
	logic [4:0]  pos_cnt = '0;
	logic        form_is_msg = 1'b0;
	logic        bad_form = 1'b0;
	logic        text_done = 1'b0;
	logic [63:0] digits_acc = '0;

	id_result_t  expected_ids[$];
	logic [7:0]  id_text[$];
	bit          no_idle = 1'b0;
	int          stall_left = 0;
	int          errors = 0;
	int          strings_sent = 0;
	int          chars_sent = 0;
	int          ids_ok_seen = 0;
	int          ids_bad_seen = 0;
	int          cycle_count = 0;

	id_hex_text_parser dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text_byte  (text_byte),
		.want_msg   (want_msg),
		.final_byte (final_byte),
		.id_valid   (id_valid),
		.id_ready   (id_ready),
		.id_ok      (id_ok),
		.id_value   (id_value)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Prefix character of either form at a position inside the prefix
	function automatic logic [7:0] prefix_char(input bit is_msg, input logic [4:0] p);
		if (is_msg) begin
			case (p)
				5'd0:    return idhex_pkg::ChM;
				5'd1:    return idhex_pkg::ChS;
				5'd2:    return idhex_pkg::ChG;
				default: return idhex_pkg::ChDash;
			endcase
		end
		case (p)
			5'd0:    return idhex_pkg::ChT;
			5'd1:    return idhex_pkg::ChR;
			default: return idhex_pkg::ChDash;
		endcase
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] d, input bit upper);
		logic [7:0] c;
		if (d < 4'd10)
			c = "0" + d;
		else if (upper)
			c = "A" + (d - 4'd10);
		else
			c = "a" + (d - 4'd10);
		return c;
	endfunction

	// Digit value 0..15, or -1 for a character that is not hex
	function automatic int hex_value(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return int'(c - "0");
		if (c >= "a" && c <= "f")
			return int'(c - "a") + 10;
		if (c >= "A" && c <= "F")
			return int'(c - "A") + 10;
		return -1;
	endfunction

	task automatic shift_digit(input logic [7:0] c);
		int d;
		d = hex_value(c);
		if (d < 0)
			bad_form = 1'b1;
		else
			digits_acc = {digits_acc[59:0], 4'(d)};
	endtask

	// Advance the parse by one accepted character; a final one queues a result
	task automatic parse_char(input logic [7:0] c, input logic want, input logic fin);
		id_result_t r;
		logic [4:0] need;
		if (pos_cnt == 5'd0 && !text_done)
			form_is_msg = want;
		if (!text_done) begin
			if (c == idhex_pkg::ChNul) begin
				text_done = 1'b1;
			end else begin
				if (form_is_msg) begin
					if (pos_cnt < idhex_pkg::MsgPrefixLen) begin
						if (c != prefix_char(1'b1, pos_cnt))
							bad_form = 1'b1;
					end else if (pos_cnt < idhex_pkg::MsgDashPos) begin
						shift_digit(c);
					end else if (pos_cnt == idhex_pkg::MsgDashPos) begin
						if (c != idhex_pkg::ChDash)
							bad_form = 1'b1;
					end else if (pos_cnt < idhex_pkg::MsgLen) begin
						shift_digit(c);
					end else begin
						bad_form = 1'b1;
					end
				end else begin
					if (pos_cnt < idhex_pkg::TracePrefixLen) begin
						if (c != prefix_char(1'b0, pos_cnt))
							bad_form = 1'b1;
					end else if (pos_cnt < idhex_pkg::TraceLen) begin
						shift_digit(c);
					end else begin
						bad_form = 1'b1;
					end
				end
				if (pos_cnt < idhex_pkg::PosMax)
					pos_cnt++;
			end
		end
		if (fin) begin
			need = form_is_msg ? idhex_pkg::MsgLen : idhex_pkg::TraceLen;
			r.ok = !bad_form && pos_cnt == need;
			r.value = r.ok ? digits_acc : 64'd0;
			expected_ids.push_back(r);
			pos_cnt = '0;
			form_is_msg = 1'b0;
			bad_form = 1'b0;
			text_done = 1'b0;
			digits_acc = '0;
		end
	endtask

	// One character request; called and returns at a falling edge
	task automatic send_char(input logic [7:0] c, input logic want, input logic fin);
		int gap;
		text_valid = 1'b1;
		text_byte = c;
		want_msg = want;
		final_byte = fin;
		do
			@(posedge clk);
		while (!text_ready);
		parse_char(c, want, fin);
		chars_sent++;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			text_valid = 1'b0;
			text_byte = 8'($urandom);
			want_msg = 1'($urandom);
			final_byte = 1'($urandom);
			repeat (gap) @(negedge clk);
		end
	endtask

	// Send id_text as one string; want_msg only matters on the first character
	task automatic send_text(input bit want);
		int n;
		n = id_text.size();
		for (int i = 0; i < n; i++)
			send_char(id_text[i], (i == 0) ? want : 1'($urandom), i == n - 1);
		strings_sent++;
	endtask

	task automatic wait_drain();
		text_valid = 1'b0;
		while (expected_ids.size() != 0)
			@(negedge clk);
	endtask

	// Fill id_text with a well-formed identifier of either form
	task automatic build_id(input bit is_msg, input digit_mode_t mode);
		logic [3:0] d;
		int plen;
		id_text.delete();
		plen = int'(is_msg ? idhex_pkg::MsgPrefixLen : idhex_pkg::TracePrefixLen);
		for (int p = 0; p < plen; p++)
			id_text.push_back(prefix_char(is_msg, 5'(p)));
		for (int i = 0; i < 16; i++) begin
			if (is_msg && i == 8)
				id_text.push_back(idhex_pkg::ChDash);
			d = (mode == DigitsZero) ? 4'h0 : (mode == DigitsMax) ? 4'hf : 4'($urandom);
			id_text.push_back(hex_char(d, 1'($urandom_range(0, 1))));
		end
	endtask

	// Empty text, zero terminator, trailing bytes, short text, wrong-case prefix
	task automatic test_corner_cases();
		id_text = '{idhex_pkg::ChNul};
		send_text(1'b0);
		id_text = '{idhex_pkg::ChNul};
		send_text(1'b1);
		id_text = '{idhex_pkg::ChT, idhex_pkg::ChNul, 8'hff, 8'h78};
		send_text(1'b0);
		id_text = '{8'hff};
		send_text(1'b0);
		id_text = '{idhex_pkg::ChM, idhex_pkg::ChS, idhex_pkg::ChG};
		send_text(1'b1);
		id_text = '{8'h54, idhex_pkg::ChR};
		send_text(1'b0);
		id_text = '{idhex_pkg::ChT, idhex_pkg::ChR, idhex_pkg::ChDash, 8'h80,
			idhex_pkg::ChNul};
		send_text(1'b0);
		id_text = '{idhex_pkg::ChM, idhex_pkg::ChS, idhex_pkg::ChG, idhex_pkg::ChDash,
			8'h7f, 8'h01};
		send_text(1'b1);
		wait_drain();
	endtask

	// Well-formed identifiers, the first two with all-zero and all-one values
	task automatic test_good_ids(input bit is_msg, input int n);
		digit_mode_t mode;
		for (int i = 0; i < n; i++) begin
			no_idle = (i >= 2 && i < 6);
			mode = (i == 0) ? DigitsZero : (i == 1) ? DigitsMax : DigitsRandom;
			build_id(is_msg, mode);
			send_text(is_msg);
		end
		no_idle = 1'b0;
		wait_drain();
	endtask

	// Sender holds off until every pending result is out
	task automatic test_drain_pauses(input int n);
		for (int i = 0; i < n; i++) begin
			build_id(i[0], DigitsRandom);
			send_text(i[0]);
			wait_drain();
		end
	endtask

	// Well-formed identifiers with one change each, most of them a defect
	task automatic test_broken_ids(input int n);
		break_kind_t kind;
		bit is_msg;
		int k;
		for (int i = 0; i < n; i++) begin
			is_msg = 1'($urandom_range(0, 1));
			build_id(is_msg, DigitsRandom);
			kind = break_kind_t'($urandom_range(0, 6));
			case (kind)
				CutShort: begin
					k = $urandom_range(1, id_text.size() - 1);
					while (id_text.size() > k)
						void'(id_text.pop_back());
				end
				AddTail: begin
					// Up to 15 extra characters; the longer tails also push the count to saturation
					k = $urandom_range(1, 15);
					repeat (k) id_text.push_back(hex_char(4'($urandom), 1'b0));
				end
				Corrupt: id_text[$urandom_range(0, id_text.size() - 1)] =
					8'($urandom_range(1, 255));
				ZeroCut: id_text[$urandom_range(0, id_text.size() - 1)] = idhex_pkg::ChNul;
				SwapForm: is_msg = !is_msg;
				PrefixCase: id_text[0] = id_text[0] ^ 8'h20;
				ZeroEnd: id_text.push_back(idhex_pkg::ChNul);
				default: ;
			endcase
			send_text((kind == SwapForm) ? is_msg : (is_msg ^ 1'b0));
		end
		wait_drain();
	endtask

	// Random bytes of random length, zero now and then
	task automatic test_noise(input int n);
		int len;
		for (int i = 0; i < n; i++) begin
			id_text.delete();
			len = $urandom_range(1, 40);
			repeat (len)
				id_text.push_back(($urandom_range(0, 7) == 0) ? idhex_pkg::ChNul
					: 8'($urandom));
			send_text(1'($urandom_range(0, 1)));
		end
		wait_drain();
	endtask

	// Result side stalls
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			id_ready = 1'b0;
		end else begin
			id_ready = 1'b1;
			if (!no_idle && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	// Compare each result with the oldest prediction
	always @(posedge clk) begin : check_ids
		id_result_t exp_r;
		if (arst_n && id_valid && id_ready) begin
			if (expected_ids.size() == 0) begin
				errors++;
				$display("%0t: id result with none expected: ok=%0b value=%h",
					$time, id_ok, id_value);
			end else begin
				exp_r = expected_ids.pop_front();
				if (id_ok !== exp_r.ok) begin
					errors++;
					$display("%0t: id_ok expected %0b actual %0b", $time, exp_r.ok, id_ok);
				end
				if (id_value !== exp_r.value) begin
					errors++;
					$display("%0t: id_value expected %h actual %h",
						$time, exp_r.value, id_value);
				end
				if (exp_r.ok)
					ids_ok_seen++;
				else
					ids_bad_seen++;
			end
		end
	end

	initial begin
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_corner_cases();
		test_good_ids(1'b0, 18);
		test_good_ids(1'b1, 18);
		test_drain_pauses(4);
		test_broken_ids(16);
		test_noise(10);
		wait_drain();
		repeat (8) @(posedge clk);
		$display("Sent %0d strings in %0d characters: trace and message forms, defects, noise.",
			strings_sent, chars_sent);
		$display("Checked %0d valid and %0d rejected identifiers.", ids_ok_seen, ids_bad_seen);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
